@@ rtl/emlbc_pkg.sv @@
package emlbc_pkg;

    localparam int unsigned CellSize = 63;
    localparam int unsigned IdxW     = 6;
    // Fraction bits of dist_value; the collision arithmetic does not depend on it.
    localparam int unsigned FracBits = 16;

    typedef struct packed {
        logic signed [31:0] dist_value;
        logic        [15:0] cell_speed_sq;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_value;
        logic [IdxW-1:0]    element_index;
        logic               last_of_cell;
    } t_out_item;

    // Decoded position of one element: direction, row, column.
    typedef struct packed {
        logic [2:0] dir;
        logic [1:0] row;
        logic [1:0] col;
    } t_pos;

    function automatic t_pos decode_pos(input logic [IdxW-1:0] e);
        t_pos p;
        logic [IdxW-1:0] r;
        p.dir = (e >= IdxW'(54)) ? 3'd6 :
                (e >= IdxW'(45)) ? 3'd5 :
                (e >= IdxW'(36)) ? 3'd4 :
                (e >= IdxW'(27)) ? 3'd3 :
                (e >= IdxW'(18)) ? 3'd2 :
                (e >= IdxW'(9))  ? 3'd1 : 3'd0;
        r     = e - IdxW'(p.dir) * IdxW'(9);
        p.row = (r >= IdxW'(6)) ? 2'd2 : (r >= IdxW'(3)) ? 2'd1 : 2'd0;
        p.col = 2'(r - IdxW'(p.row) * IdxW'(3));
        return p;
    endfunction

endpackage

@@ rtl/emlbc_div.sv @@
// Restoring divider for the rest-direction quotient: one quotient bit a cycle.
module emlbc_div import emlbc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic        [63:0] i_num,
    input  logic        [16:0] i_den,
    output logic               o_busy,
    output logic        [63:0] o_quo
);
    logic [63:0] r_quo;
    logic [16:0] r_den;
    logic [17:0] r_rem;
    logic [6:0]  r_cnt;
    logic [17:0] w_trial;
    logic [17:0] w_sub;

    assign w_trial = {r_rem[16:0], r_quo[63]};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= 7'd64;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 7'd1;
            if (!w_sub[17]) begin
                r_rem <= w_sub;
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;
endmodule

@@ rtl/em_lattice_boltzmann_collision.sv @@
// Collision kernel for one D3Q7 electromagnetic lattice Boltzmann cell. Feed
// the cell's 63 distributions in direction, row, column order; cell_speed_sq is
// taken with the first, and a zero speed counts as one. E and B moments are
// accumulated as the loads arrive. After the 63rd load the block stops taking
// input and scales the moments, the E sums through one shared multiplier. Each
// moving-direction element then passes S_LAM, where its old value is read, and
// S_EMIT, which forms and registers the result; both hold while the output is
// stalled. Each rest-direction element also passes S_DIV and S_DIVW, where the
// bit-serial divider forms its quotient. Results are 2*feq - f, saturated.
module em_lattice_boltzmann_collision import emlbc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);
    typedef enum logic [2:0] {S_LOAD, S_SCALE, S_LAM, S_DIV, S_DIVW, S_EMIT} t_state;

    t_state r_state;
    logic [31:0] r_buf [0:CellSize-1];
    logic signed [47:0] r_esum [3];
    logic signed [47:0] r_bsum [3];
    logic signed [47:0] r_ef [3];
    logic signed [47:0] r_bf [3];
    logic [IdxW-1:0] r_cnt;
    logic [15:0] r_spd;
    logic [2:0]  r_sc;
    logic signed [31:0] r_old;
    logic signed [63:0] r_lam2;
    logic r_neg;
    t_out_item r_out;
    logic      r_ovld;

    // Shared multiplier: speed times E sum, and (1 - 3 c2) times Lambda.
    logic signed [47:0] w_ma;
    logic signed [18:0] w_mb;
    logic signed [63:0] w_prod;
    logic [16:0] w_s;
    t_pos w_ip, w_kp;
    logic signed [63:0] w_lam, w_twofeq, w_diff, w_num;
    logic [1:0] w_g;
    logic w_div_busy, w_div_start;
    logic [63:0] w_quo;
    logic [63:0] w_mag;

    function automatic logic w_dir_v(input logic [2:0] d);
        return d[0];
    endfunction

    assign w_s  = (r_spd == '0) ? 17'd1 : {1'b0, r_spd};
    assign w_ip = decode_pos(r_cnt);
    assign w_kp = decode_pos(r_cnt);
    assign o_stall = (r_state != S_LOAD);
    assign o_valid = r_ovld;
    assign o_data  = r_out;

    always_comb begin
        w_g = 2'd3 - w_kp.row - w_kp.col;
        w_lam = '0;
        if (w_kp.row != w_kp.col) begin
            // lev(g,a,b) positive on cyclic order; Lambda = -lev*E_g
            if ((w_kp.row == 2'd0 && w_kp.col == 2'd1) || (w_kp.row == 2'd1 && w_kp.col == 2'd2)
                || (w_kp.row == 2'd2 && w_kp.col == 2'd0))
                w_lam = -64'(r_ef[w_g]);
            else
                w_lam = 64'(r_ef[w_g]);
        end
    end

    always_comb begin
        w_ma = r_esum[r_sc[1:0]];
        w_mb = signed'({2'b00, w_s});
        if (r_state == S_LAM) begin
            w_ma = 48'(w_lam);
            w_mb = 19'sd65536 - 19'sd3 * signed'({2'b00, w_s});
        end
    end
    assign w_prod = 64'(w_ma) * 64'(w_mb);

    assign w_num  = r_lam2;
    assign w_mag  = w_num[63] ? 64'(-w_num) : 64'(w_num);
    assign w_div_start = (r_state == S_DIV);

    emlbc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_mag + 64'(w_s >> 1)), .i_den(w_s),
        .o_busy(w_div_busy), .o_quo(w_quo)
    );

    always_comb begin
        w_twofeq = w_lam;
        if (w_kp.dir != 3'd0) begin
            // +V on odd directions along axis l
            if (w_kp.row == 2'((w_kp.dir - 3'd1) >> 1))
                w_twofeq = w_dir_v(w_kp.dir) ? w_twofeq + 64'(r_bf[w_kp.col])
                                             : w_twofeq - 64'(r_bf[w_kp.col]);
            if (w_kp.col == 2'((w_kp.dir - 3'd1) >> 1))
                w_twofeq = w_dir_v(w_kp.dir) ? w_twofeq - 64'(r_bf[w_kp.row])
                                             : w_twofeq + 64'(r_bf[w_kp.row]);
        end else begin
            w_twofeq = r_neg ? 64'(-w_quo) : 64'(w_quo);
        end
        w_diff = w_twofeq - 64'(r_old);
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && r_state == S_LOAD) r_buf[r_cnt] <= i_data.dist_value;
        r_old <= r_buf[r_cnt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_spd   <= '0;
            r_sc    <= '0;
            r_ovld  <= 1'b0;
            r_neg   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_esum[i] <= '0;
                r_bsum[i] <= '0;
                r_ef[i]   <= '0;
                r_bf[i]   <= '0;
            end
        end else begin
            // set on an emit, hold while stalled, drop once taken
            r_ovld <= (r_state == S_EMIT && (!r_ovld || !i_stall)) || (r_ovld && i_stall);
            unique case (r_state)
                S_LOAD: if (i_valid) begin
                    // accumulate the moments of this element
                    if (r_cnt == '0) r_spd <= i_data.cell_speed_sq;
                    if (w_ip.row != w_ip.col) begin
                        if ((w_ip.row == 2'd0 && w_ip.col == 2'd1)
                            || (w_ip.row == 2'd1 && w_ip.col == 2'd2)
                            || (w_ip.row == 2'd2 && w_ip.col == 2'd0))
                            r_esum[2'd3 - w_ip.row - w_ip.col] <=
                                r_esum[2'd3 - w_ip.row - w_ip.col] + 48'(i_data.dist_value);
                        else
                            r_esum[2'd3 - w_ip.row - w_ip.col] <=
                                r_esum[2'd3 - w_ip.row - w_ip.col] - 48'(i_data.dist_value);
                    end
                    if (w_ip.dir != 3'd0) begin
                        if (w_ip.col == 2'((w_ip.dir - 3'd1) >> 1)
                            && w_ip.row != w_ip.col)
                            r_bsum[w_ip.row] <= w_ip.dir[0]
                                ? r_bsum[w_ip.row] + 48'(i_data.dist_value)
                                : r_bsum[w_ip.row] - 48'(i_data.dist_value);
                        if (w_ip.row == 2'((w_ip.dir - 3'd1) >> 1)
                            && w_ip.row != w_ip.col)
                            r_bsum[w_ip.col] <= w_ip.dir[0]
                                ? r_bsum[w_ip.col] - 48'(i_data.dist_value)
                                : r_bsum[w_ip.col] + 48'(i_data.dist_value);
                    end
                    if (r_cnt == IdxW'(CellSize - 1)) begin
                        r_cnt   <= '0;
                        r_sc    <= '0;
                        r_state <= S_SCALE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SCALE: begin
                    // E_g = -round(s*sum/2^17), B = -round(sum/4)
                    r_ef[r_sc[1:0]] <= 48'(-((w_prod + 64'sd65536) >>> 17));
                    r_bf[r_sc[1:0]] <= 48'(-((64'(r_bsum[r_sc[1:0]]) + 64'sd2) >>> 2));
                    if (r_sc == 3'd2) begin
                        r_state <= S_LAM;
                        r_sc    <= '0;
                        for (int i = 0; i < 3; i++) begin
                            r_esum[i] <= '0;
                            r_bsum[i] <= '0;
                        end
                    end else begin
                        r_sc <= r_sc + 3'd1;
                    end
                end
                S_LAM: if (!r_ovld || !i_stall) begin
                    if (w_kp.dir == 3'd0) begin
                        r_lam2  <= w_prod <<< 1;
                        r_neg   <= w_prod[63];
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_DIV:  r_state <= S_DIVW;
                S_DIVW: if (!w_div_busy) r_state <= S_EMIT;
                S_EMIT: if (!r_ovld || !i_stall) begin
                    r_out.new_value <= (w_diff > 64'sd2147483647) ? 32'sh7fffffff
                                     : (w_diff < -64'sd2147483648) ? 32'sh80000000
                                     : 32'(w_diff);
                    r_out.element_index <= r_cnt;
                    r_out.last_of_cell  <= (r_cnt == IdxW'(CellSize - 1));
                    if (r_cnt == IdxW'(CellSize - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_LAM;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && i_valid && r_cnt == IdxW'(CellSize - 1)) |=> r_state == S_SCALE)
        else $error("cell end not followed by scaling");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> o_stall)
        else $error("input taken while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_out.last_of_cell) |-> r_out.element_index == IdxW'(CellSize - 1))
        else $error("last flag on wrong element");
endmodule
